@@ design/dshot_pkg.sv @@
`default_nettype none
package dshot_pkg;

  // Field widths fixed by the frame format.
  localparam int unsigned ValueW   = 11;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned TicksW   = 8;
  localparam int unsigned GapW     = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ReqW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ItemIdxW = 5;

  // Sixteen pulse items, then the gap item.
  localparam logic [ItemIdxW-1:0] GapItemIdx = 5'd16;
  localparam logic [ValueW-1:0]   ValueMax   = 11'd2047;
  localparam logic [CountW-1:0]   CountMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ARM_TOGGLE      = 2'd0,
    OP_STOP            = 2'd1,
    OP_THROTTLE_TOGGLE = 2'd2,
    OP_FRAME_SLOT      = 2'd3
  } dshot_op_e;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMING   = 2'd1,
    MODE_ARMED    = 2'd2
  } dshot_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH      = 3'd0,
    CFG_ONE_LOW       = 3'd1,
    CFG_ZERO_HIGH     = 3'd2,
    CFG_ZERO_LOW      = 3'd3,
    CFG_GAP           = 3'd4,
    CFG_ARMING_FRAMES = 3'd5,
    CFG_IDLE_THROTTLE = 3'd6
  } dshot_cfg_idx_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [ReqW-1:0] throttle_request;
  } dshot_in_t;

  typedef struct packed {
    logic              bit_value;
    logic [TicksW-1:0] high_ticks;
    logic [GapW-1:0]   low_ticks;
    logic              is_gap;
    logic [FrameW-1:0] frame_word;
    logic              last;
  } dshot_out_t;

  typedef struct packed {
    logic [TicksW-1:0] one_high_ticks;
    logic [TicksW-1:0] one_low_ticks;
    logic [TicksW-1:0] zero_high_ticks;
    logic [TicksW-1:0] zero_low_ticks;
    logic [GapW-1:0]   gap_ticks;
    logic [CountW-1:0] arming_frames;
    logic [ValueW-1:0] idle_throttle;
  } dshot_cfg_t;

  // Value, telemetry bit zero, then the XOR of the three nibbles.
  function automatic logic [FrameW-1:0] build_frame(logic [ValueW-1:0] value);
    logic [ValueW:0] word;
    logic [3:0]      crc;
    word = {value, 1'b0};
    crc  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, crc};
  endfunction

endpackage
`default_nettype wire

@@ design/dshot_fifo.sv @@
`default_nettype none
module dshot_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

@@ design/dshot_front.sv @@
`default_nettype none
module dshot_front
  import dshot_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dshot_cfg_t        cfg_i,
  input  wire logic              accept_i,
  input  wire dshot_in_t         item_i,
  output logic                   fq_push_o,
  output logic      [FrameW-1:0] fq_data_o
);

  dshot_mode_e       mode_q, mode_d;
  logic              thr_en_q, thr_en_d;
  logic [CountW-1:0] arm_cnt_q, arm_cnt_d;
  logic [CountW-1:0] arm_cnt_inc;
  logic [ValueW-1:0] req_sat;
  logic [ValueW-1:0] value;
  dshot_op_e         op;

  assign op          = dshot_op_e'(item_i.op);
  assign arm_cnt_inc = (arm_cnt_q == CountMax) ? arm_cnt_q : arm_cnt_q + 1'b1;
  assign req_sat     = item_i.throttle_request[ReqW-1] ? ValueMax
                                                       : item_i.throttle_request[ValueW-1:0];

  // Next mode, throttle flag and arming count.
  always_comb begin
    mode_d    = mode_q;
    thr_en_d  = thr_en_q;
    arm_cnt_d = arm_cnt_q;
    if (accept_i) begin
      case (op)
        OP_ARM_TOGGLE: begin
          if (mode_q == MODE_ARMED) begin
            mode_d   = MODE_DISARMED;
            thr_en_d = 1'b0;
          end else if (mode_q != MODE_ARMING) begin
            mode_d    = MODE_ARMING;
            arm_cnt_d = '0;
          end
        end
        OP_STOP: begin
          mode_d    = MODE_DISARMED;
          thr_en_d  = 1'b0;
          arm_cnt_d = '0;
        end
        OP_THROTTLE_TOGGLE: begin
          if (mode_q == MODE_ARMED) begin
            thr_en_d = !thr_en_q;
          end
        end
        OP_FRAME_SLOT: begin
          if (mode_q == MODE_ARMING) begin
            arm_cnt_d = arm_cnt_inc;
            if (arm_cnt_inc >= cfg_i.arming_frames) begin
              mode_d = MODE_ARMED;
            end
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // Frame value and queue push for a frame slot outside the disarmed mode.
  always_comb begin
    fq_push_o = 1'b0;
    value     = '0;
    case (mode_q)
      MODE_ARMING: begin
        fq_push_o = accept_i && (op == OP_FRAME_SLOT);
        value     = '0;
      end
      MODE_ARMED: begin
        fq_push_o = accept_i && (op == OP_FRAME_SLOT);
        value     = thr_en_q ? req_sat : cfg_i.idle_throttle;
      end
      default: begin
        fq_push_o = 1'b0;
        value     = '0;
      end
    endcase
  end

  assign fq_data_o = build_frame(value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_DISARMED;
      thr_en_q  <= 1'b0;
      arm_cnt_q <= '0;
    end else begin
      mode_q    <= mode_d;
      thr_en_q  <= thr_en_d;
      arm_cnt_q <= arm_cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ design/dshot_back.sv @@
`default_nettype none
module dshot_back
  import dshot_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dshot_cfg_t        cfg_i,
  input  wire logic              fq_empty_i,
  input  wire logic [FrameW-1:0] fq_data_i,
  output logic                   fq_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output dshot_out_t             item_o
);

  logic                busy_q, busy_d;
  logic [ItemIdxW-1:0] idx_q, idx_d;
  logic [FrameW-1:0]   frame_q;
  logic                out_valid_q, out_valid_d;
  dshot_out_t          out_q, item_next;
  logic                advance, at_gap, load, cur_bit;

  // An item moves into the output register when it is free or being drained.
  assign advance  = busy_q && (!out_valid_q || pop_i);
  assign at_gap   = (idx_q == GapItemIdx);
  assign load     = !fq_empty_i && (!busy_q || (advance && at_gap));
  assign fq_pop_o = load;
  assign empty_o  = !out_valid_q;
  assign item_o   = out_q;

  // MSB first: item k carries frame bit 15 - k.
  assign cur_bit = frame_q[~idx_q[3:0]];

  always_comb begin
    item_next.frame_word = frame_q;
    if (at_gap) begin
      item_next.bit_value  = 1'b0;
      item_next.high_ticks = '0;
      item_next.low_ticks  = cfg_i.gap_ticks;
      item_next.is_gap     = 1'b1;
      item_next.last       = 1'b1;
    end else begin
      item_next.bit_value  = cur_bit;
      item_next.high_ticks = cur_bit ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
      item_next.low_ticks  = {8'd0, cur_bit ? cfg_i.one_low_ticks : cfg_i.zero_low_ticks};
      item_next.is_gap     = 1'b0;
      item_next.last       = 1'b0;
    end
  end

  // Serializer control.
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (advance) begin
      busy_d = !at_gap;
      idx_d  = idx_q + 1'b1;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= fq_data_i;
    end
    if (advance) begin
      out_q <= item_next;
    end
  end

endmodule
`default_nettype wire

@@ design/dshot_esc_arming_frame_transmitter_top.sv @@
// DShot ESC arming frame transmitter.
//
// Input channel (push/full): each transaction is a button event (arm toggle,
// stop, throttle toggle) or a frame slot carrying a requested throttle.
// Result channel (empty/pop): pulse items, each with its bit, high and low
// tick counts and the whole frame word. A frame is 16 pulse items, MSB first,
// followed by one gap item that has is_gap and last set.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while the block is idle.
// The first item of an accepted frame slot passes the frame queue, the
// serializer's frame register and the output register. The serializer sends
// one item per cycle while the receiver pops, and loads the next frame as it
// sends the gap item; the input side runs ahead until the frame queue is full.
// When the receiver stalls, the output register holds its item and the
// serializer, then the frame queue, fill up; full then rises on the input.
// Reset puts the ESC in the disarmed mode, clears the throttle flag, arming
// count, frame queue and output register, and loads the register defaults.
`default_nettype none
module dshot_esc_arming_frame_transmitter_top
  import dshot_pkg::*;
#(
  parameter int unsigned FRAME_QUEUE_DEPTH = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire dshot_in_t           in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output dshot_out_t               out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  dshot_cfg_t        cfg_q;
  logic              accept;
  logic              fq_push, fq_pop, fq_full, fq_empty;
  logic [FrameW-1:0] fq_wdata, fq_rdata;

  assign full   = fq_full;
  assign accept = push && !fq_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high_ticks  <= 8'd12;
      cfg_q.one_low_ticks   <= 8'd4;
      cfg_q.zero_high_ticks <= 8'd6;
      cfg_q.zero_low_ticks  <= 8'd10;
      cfg_q.gap_ticks       <= 16'd5000;
      cfg_q.arming_frames   <= 16'd1000;
      cfg_q.idle_throttle   <= 11'd48;
    end else if (cfg_we_i) begin
      case (dshot_cfg_idx_e'(cfg_idx_i))
        CFG_ONE_HIGH:      cfg_q.one_high_ticks  <= cfg_data_i[TicksW-1:0];
        CFG_ONE_LOW:       cfg_q.one_low_ticks   <= cfg_data_i[TicksW-1:0];
        CFG_ZERO_HIGH:     cfg_q.zero_high_ticks <= cfg_data_i[TicksW-1:0];
        CFG_ZERO_LOW:      cfg_q.zero_low_ticks  <= cfg_data_i[TicksW-1:0];
        CFG_GAP:           cfg_q.gap_ticks       <= cfg_data_i[GapW-1:0];
        CFG_ARMING_FRAMES: cfg_q.arming_frames   <= cfg_data_i[CountW-1:0];
        CFG_IDLE_THROTTLE: cfg_q.idle_throttle   <= cfg_data_i[ValueW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front end: mode tracking and frame building.
  dshot_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .fq_push_o (fq_push),
    .fq_data_o (fq_wdata)
  );

  // Frame queue between the two sides.
  dshot_fifo #(
    .WIDTH (FrameW),
    .DEPTH (FRAME_QUEUE_DEPTH)
  ) u_frame_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_wdata),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .full_o  (fq_full),
    .empty_o (fq_empty)
  );

  // Back end: pulse serializer with output register.
  dshot_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .fq_empty_i (fq_empty),
    .fq_data_i  (fq_rdata),
    .fq_pop_o   (fq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .item_o     (out_item_o)
  );

  // A frame is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_push |-> !fq_full)
    else $error("frame pushed into full queue");

  // The gap item alone ends a frame and drives no high time.
  a_gap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last == out_item_o.is_gap) &&
               (!out_item_o.is_gap || (out_item_o.high_ticks == '0)))
    else $error("gap item marking inconsistent");

  // A pulse item taken by the receiver is followed by another item of the same frame.
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last) |=>
      (!empty && (out_item_o.frame_word == $past(out_item_o.frame_word))))
    else $error("frame run broken");

endmodule
`default_nettype wire

@@ bench/dshot_frame_checker.sv @@
`timescale 1ns / 1ps
// Watches the input, result and register ports of the transmitter, keeps its
// own copy of the ESC mode and the register set, and checks every popped
// pulse item against the oldest predicted one.
module dshot_frame_checker
  import dshot_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic                full_i,
  input  wire dshot_in_t           in_item_i,
  input  wire logic                empty_i,
  input  wire logic                pop_i,
  input  wire dshot_out_t          out_item_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  // Shadow copy of the block's registers and ESC state.
  dshot_cfg_t        regs;
  dshot_mode_e       esc_mode;
  logic              thr_enabled;
  logic [CountW-1:0] arm_frames_sent;

  // Pulse items that the block still owes, oldest first.
  dshot_out_t pulse_queue[$];

  assign pending_o = pulse_queue.size();

  // Frame word: value, telemetry zero, XOR of the three nibbles above.
  function automatic logic [FrameW-1:0] encode_frame(logic [ValueW-1:0] value);
    logic [ValueW:0] payload;
    logic [3:0]      nib_sum;
    int              n;
    payload = {value, 1'b0};
    nib_sum = 4'h0;
    for (n = 0; n < 3; n++) nib_sum ^= payload[n*4 +: 4];
    return {payload, nib_sum};
  endfunction

  // Queue the sixteen pulse items of a frame, MSB first, then the gap item.
  task automatic queue_frame(logic [ValueW-1:0] value);
    logic [FrameW-1:0] word;
    dshot_out_t        pulse;
    int                i;
    word = encode_frame(value);
    for (i = FrameW - 1; i >= 0; i--) begin
      pulse.bit_value  = word[i];
      pulse.high_ticks = word[i] ? regs.one_high_ticks : regs.zero_high_ticks;
      pulse.low_ticks  = GapW'(word[i] ? regs.one_low_ticks : regs.zero_low_ticks);
      pulse.is_gap     = 1'b0;
      pulse.frame_word = word;
      pulse.last       = 1'b0;
      pulse_queue.push_back(pulse);
    end
    pulse.bit_value  = 1'b0;
    pulse.high_ticks = '0;
    pulse.low_ticks  = regs.gap_ticks;
    pulse.is_gap     = 1'b1;
    pulse.frame_word = word;
    pulse.last       = 1'b1;
    pulse_queue.push_back(pulse);
  endtask

  // Advance the ESC state for one accepted input transaction.
  task automatic apply_event(dshot_in_t ev);
    case (dshot_op_e'(ev.op))
      OP_ARM_TOGGLE: begin
        if (esc_mode == MODE_ARMED) begin
          esc_mode    = MODE_DISARMED;
          thr_enabled = 1'b0;
        end else if (esc_mode != MODE_ARMING) begin
          esc_mode        = MODE_ARMING;
          arm_frames_sent = '0;
        end
      end
      OP_STOP: begin
        esc_mode        = MODE_DISARMED;
        thr_enabled     = 1'b0;
        arm_frames_sent = '0;
      end
      OP_THROTTLE_TOGGLE: begin
        if (esc_mode == MODE_ARMED) thr_enabled = ~thr_enabled;
      end
      default: begin
        if (esc_mode == MODE_ARMING) begin
          queue_frame('0);
          if (arm_frames_sent != CountMax) arm_frames_sent++;
          // A zero frame count behaves like one, since the count is at least one here.
          if (arm_frames_sent >= regs.arming_frames) esc_mode = MODE_ARMED;
        end else if (esc_mode == MODE_ARMED) begin
          if (!thr_enabled) queue_frame(regs.idle_throttle);
          else if (ev.throttle_request > ReqW'(ValueMax)) queue_frame(ValueMax);
          else queue_frame(ev.throttle_request[ValueW-1:0]);
        end
      end
    endcase
  endtask

  // Compare one popped transaction with the oldest prediction.
  task automatic check_pulse(dshot_out_t got);
    dshot_out_t want;
    if (pulse_queue.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected pulse item bit=%0d high=%0d low=%0d gap=%0d word=%h last=%0d",
                 $realtime, got.bit_value, got.high_ticks, got.low_ticks, got.is_gap,
                 got.frame_word, got.last);
      return;
    end
    want = pulse_queue.pop_front();
    checked_o++;
    if (got.bit_value !== want.bit_value || got.high_ticks !== want.high_ticks ||
        got.low_ticks !== want.low_ticks || got.is_gap !== want.is_gap ||
        got.frame_word !== want.frame_word || got.last !== want.last) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: pulse mismatch, expected bit=%0d high=%0d low=%0d gap=%0d word=%h last=%0d",
                 $realtime, want.bit_value, want.high_ticks, want.low_ticks, want.is_gap,
                 want.frame_word, want.last);
        $display("%0t:                 actual   bit=%0d high=%0d low=%0d gap=%0d word=%h last=%0d",
                 $realtime, got.bit_value, got.high_ticks, got.low_ticks, got.is_gap,
                 got.frame_word, got.last);
      end
    end
  endtask

  // Sample all three ports on the rising edge, before the block updates them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.one_high_ticks  = 8'd12;
      regs.one_low_ticks   = 8'd4;
      regs.zero_high_ticks = 8'd6;
      regs.zero_low_ticks  = 8'd10;
      regs.gap_ticks       = 16'd5000;
      regs.arming_frames   = 16'd1000;
      regs.idle_throttle   = 11'd48;
      esc_mode        = MODE_DISARMED;
      thr_enabled     = 1'b0;
      arm_frames_sent = '0;
      fail_count_o    = 0;
      checked_o       = 0;
      pulse_queue.delete();
    end else begin
      if (cfg_we_i) begin
        case (dshot_cfg_idx_e'(cfg_idx_i))
          CFG_ONE_HIGH:      regs.one_high_ticks  = cfg_data_i[TicksW-1:0];
          CFG_ONE_LOW:       regs.one_low_ticks   = cfg_data_i[TicksW-1:0];
          CFG_ZERO_HIGH:     regs.zero_high_ticks = cfg_data_i[TicksW-1:0];
          CFG_ZERO_LOW:      regs.zero_low_ticks  = cfg_data_i[TicksW-1:0];
          CFG_GAP:           regs.gap_ticks       = cfg_data_i[GapW-1:0];
          CFG_ARMING_FRAMES: regs.arming_frames   = cfg_data_i[CountW-1:0];
          CFG_IDLE_THROTTLE: regs.idle_throttle   = cfg_data_i[ValueW-1:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) apply_event(in_item_i);
      if (pop_i && !empty_i) check_pulse(out_item_i);
    end
  end

endmodule

@@ bench/tb_dshot_esc_arming_frame_transmitter_top.sv @@
`timescale 1ns / 1ps
// Drives button and frame slot transactions into the transmitter, pops its
// pulse items with random stalls, reprograms the registers between phases
// and reports the checker's verdict.
module tb_dshot_esc_arming_frame_transmitter_top;
  import dshot_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam int unsigned MaxWait = 17;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned RandomItems = 210;
  localparam longint TimeoutNs = 10_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  dshot_in_t           in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  dshot_out_t          out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent = 0;
  int unsigned cfg_sets = 0;
  int unsigned calm_in = 0;
  int unsigned calm_out = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dshot_esc_arming_frame_transmitter_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dshot_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Random wait per transaction, with occasional runs of back-to-back transfers.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // Present one input transaction and hold it until it is taken.
  task automatic send_item(dshot_op_e op, logic [ReqW-1:0] req);
    dshot_in_t   ev;
    int unsigned gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev.op = op;
    ev.throttle_request = req;
    push    <= 1'b1;
    in_item <= ev;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted pulse item has been popped.
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Program the whole register set; the block must be idle.
  task automatic apply_cfg(logic [15:0] one_hi, logic [15:0] one_lo, logic [15:0] zero_hi,
                           logic [15:0] zero_lo, logic [15:0] gap, logic [15:0] arm_frames,
                           logic [15:0] idle);
    write_reg(CFG_ONE_HIGH, one_hi);
    write_reg(CFG_ONE_LOW, one_lo);
    write_reg(CFG_ZERO_HIGH, zero_hi);
    write_reg(CFG_ZERO_LOW, zero_lo);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_ARMING_FRAMES, arm_frames);
    write_reg(CFG_IDLE_THROTTLE, idle);
    cfg_sets++;
  endtask

  // Result side: pop with a random stall before each transaction.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(calm_out);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned      random_sent;
    int unsigned      arm_frames;
    int unsigned      seq_len;
    int unsigned      pick;
    logic [ReqW-1:0]  req;
    logic [15:0]      gap;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disarmed: frame slots, throttle toggles and stops change nothing.
    send_item(OP_FRAME_SLOT, 12'hFFF);
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_STOP, 12'h800);
    // Arming with the reset defaults, then aborted by a stop.
    send_item(OP_ARM_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h7FF);
    send_item(OP_ARM_TOGGLE, 12'h123);
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h000);
    send_item(OP_STOP, 12'h000);
    send_item(OP_FRAME_SLOT, 12'hABC);
    settle();

    // Upper extremes; a zero frame count arms after one frame; a spare index.
    apply_cfg(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    write_reg(CfgIdxSpare, 16'hFFFF);
    send_item(OP_ARM_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h000);
    send_item(OP_FRAME_SLOT, 12'hFFF);
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'hFFF);
    send_item(OP_FRAME_SLOT, 12'h800);
    send_item(OP_FRAME_SLOT, 12'h7FF);
    send_item(OP_FRAME_SLOT, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h555);
    send_item(OP_FRAME_SLOT, 12'hAAA);
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h3C3);
    send_item(OP_ARM_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h111);
    send_item(OP_ARM_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'h222);
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_STOP, 12'hFFF);
    send_item(OP_FRAME_SLOT, 12'hFFF);
    settle();

    // Lower extremes and the largest frame count: arming never completes.
    apply_cfg(16'h0000, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(OP_ARM_TOGGLE, 12'h000);
    repeat (3) send_item(OP_FRAME_SLOT, ReqW'($urandom_range(0, 4095)));
    send_item(OP_THROTTLE_TOGGLE, 12'h000);
    send_item(OP_FRAME_SLOT, 12'hFFF);
    send_item(OP_STOP, 12'h000);
    settle();

    // Random phases: each reprograms the registers, arms, then runs frames.
    random_sent = 0;
    while (random_sent < RandomItems) begin
      arm_frames = $urandom_range(0, 4);
      gap = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      apply_cfg(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), gap,
                16'(arm_frames), 16'($urandom_range(0, 65535)));
      send_item(OP_STOP, ReqW'($urandom_range(0, 4095)));
      send_item(OP_ARM_TOGGLE, ReqW'($urandom_range(0, 4095)));
      repeat ((arm_frames == 0) ? 1 : arm_frames)
        send_item(OP_FRAME_SLOT, ReqW'($urandom_range(0, 4095)));
      random_sent += 2 + ((arm_frames == 0) ? 1 : arm_frames);
      seq_len = $urandom_range(15, 35);
      repeat (seq_len) begin
        pick = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
          0: req = 12'h000;
          1: req = 12'h7FF;
          2: req = 12'h800;
          3: req = 12'hFFF;
          default: req = ReqW'($urandom_range(0, 4095));
        endcase
        if (pick < 6) send_item(OP_FRAME_SLOT, req);
        else if (pick < 8) send_item(OP_THROTTLE_TOGGLE, req);
        else send_item(dshot_op_e'(2'($urandom_range(0, 3))), req);
      end
      random_sent += seq_len;
      settle();
    end

    $display("Sent %0d input transactions over %0d register settings;", items_sent, cfg_sets);
    $display("checked %0d pulse items with both sides stalling at random.", checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
